### rtl/core/q4_k_block_dequantizer_top_assert.svh
// Assertion macros for the Q4_K block dequantizer.
// Used by q4_k_block_dequantizer_top; needs a clock and a reset signal name.
`ifndef Q4_K_BLOCK_DEQUANTIZER_TOP_ASSERT_SVH
`define Q4_K_BLOCK_DEQUANTIZER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define Q4KD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define Q4KD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define Q4KD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define Q4KD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/core/q4kd_pkg.sv
// Q4_K dequantizer package: types, constants and fp16 arithmetic helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package q4kd_pkg;

   localparam int LANES = 8;
   localparam logic [4:0] LAST_WORD = 5'd17;
   localparam logic [4:0] FIRST_DATA_WORD = 5'd2;

   localparam logic [1:0] FMT_FP16 = 2'd0;
   localparam logic [1:0] FMT_BF16 = 2'd1;
   localparam logic [1:0] FMT_FP32 = 2'd2;
   localparam logic [1:0] FMT_RSVD = 2'd3;

   localparam logic [15:0] H_QNAN = 16'h7E00;
   localparam logic [14:0] H_INF = 15'h7C00;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_PROD,
      ST_DIFF,
      ST_EMIT
   } q4kd_state_type;

   typedef struct packed {
      logic prod_en;
      logic diff_en;
   } q4kd_lane_ctrl_type;

   // fp16 magnitude as integer in units of 2^-24 (finite inputs only)
   function automatic logic [40:0] h_mag(input logic [15:0] h);
      logic [40:0] r;
      if (h[14:10] == 5'd0) begin
         r = {31'd0, h[9:0]};
      end else begin
         r = {30'd0, 1'b1, h[9:0]} << (h[14:10] - 5'd1);
      end
      return r;
   endfunction

   // round sign/magnitude (units 2^-24) to fp16, nearest even
   function automatic logic [15:0] round_h(input logic s, input logic [46:0] mag);
      logic [5:0]  p;
      logic [5:0]  sh;
      logic [46:0] q;
      logic [46:0] rem;
      logic [46:0] half;
      logic [47:0] enc;
      logic [15:0] res;
      p = 6'd0;
      for (int i = 0; i < 47; i++) begin
         if (mag[i]) p = i[5:0];
      end
      if (mag == 47'd0) begin
         res = {s, 15'd0};
      end else if (p <= 6'd10) begin
         res = {s, mag[14:0]};
      end else begin
         sh   = p - 6'd10;
         q    = mag >> sh;
         rem  = mag & ((47'd1 << sh) - 47'd1);
         half = 47'd1 << (sh - 6'd1);
         if (rem > half || (rem == half && q[0])) q = q + 47'd1;
         enc = {32'd0, sh, 10'd0} + {1'b0, q};
         if (enc >= {33'd0, H_INF}) res = {s, H_INF};
         else res = {s, enc[14:0]};
      end
      return res;
   endfunction

   // fp16 times small unsigned integer, rounded to fp16
   function automatic logic [15:0] mul_h(input logic [15:0] h, input logic [5:0] n);
      logic [15:0] res;
      logic [46:0] prod;
      prod = {6'd0, h_mag(h)} * {41'd0, n};
      if (h[14:10] == 5'h1F) begin
         if (h[9:0] != 10'd0 || n == 6'd0) res = H_QNAN;
         else res = {h[15], H_INF};
      end else begin
         res = round_h(h[15], prod);
      end
      return res;
   endfunction

   // a - b in fp16, single rounding
   function automatic logic [15:0] sub_h(input logic [15:0] a, input logic [15:0] b);
      logic [15:0] res;
      logic        a_nan;
      logic        b_nan;
      logic        a_inf;
      logic        b_inf;
      logic [40:0] ma;
      logic [40:0] mb;
      a_nan = (a[14:10] == 5'h1F) && (a[9:0] != 10'd0);
      b_nan = (b[14:10] == 5'h1F) && (b[9:0] != 10'd0);
      a_inf = (a[14:10] == 5'h1F) && (a[9:0] == 10'd0);
      b_inf = (b[14:10] == 5'h1F) && (b[9:0] == 10'd0);
      ma = h_mag(a);
      mb = h_mag(b);
      if (a_nan || b_nan) begin
         res = H_QNAN;
      end else if (a_inf) begin
         res = (b_inf && a[15] == b[15]) ? H_QNAN : a;
      end else if (b_inf) begin
         res = {~b[15], H_INF};
      end else if (ma == 41'd0 && mb == 41'd0) begin
         res = {a[15] & ~b[15], 15'd0};
      end else if (a[15] != b[15]) begin
         res = round_h(a[15], {6'd0, ma} + {6'd0, mb});
      end else if (ma == mb) begin
         res = 16'd0;
      end else if (ma > mb) begin
         res = round_h(a[15], {6'd0, ma - mb});
      end else begin
         res = round_h(~a[15], {6'd0, mb - ma});
      end
      return res;
   endfunction

   function automatic logic [31:0] h_to_f32(input logic [15:0] h);
      logic [31:0] f;
      logic [3:0]  p;
      logic [9:0]  m;
      logic [7:0]  ex;
      p = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (h[i]) p = i[3:0];
      end
      m  = h[9:0] << (4'd10 - p);
      ex = 8'd103 + {4'd0, p};
      if (h[14:10] == 5'h1F) begin
         f = (h[9:0] != 10'd0) ? 32'h7FC0_0000 : {h[15], 31'h7F80_0000};
      end else if (h[14:10] == 5'd0) begin
         f = (h[9:0] == 10'd0) ? {h[15], 31'd0} : {h[15], ex, m, 13'd0};
      end else begin
         f = {h[15], {3'd0, h[14:10]} + 8'd112, h[9:0], 13'd0};
      end
      return f;
   endfunction

   function automatic logic [31:0] encode_h(input logic [15:0] h, input logic [1:0] fmt);
      logic [31:0] f;
      logic [31:0] sum;
      logic [31:0] res;
      f   = h_to_f32(h);
      sum = f + 32'h0000_7FFF + {31'd0, f[16]};
      if (fmt == FMT_FP16) begin
         res = {16'd0, h};
      end else if (fmt == FMT_BF16) begin
         res = (f[30:0] > 31'h7F80_0000) ? 32'h0000_7FC0 : {16'd0, sum[31:16]};
      end else begin
         res = f;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

### rtl/core/q4kd_req_if.sv
// Request channel interface: valid/ready plus one 64-bit block word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface q4kd_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_word;

   modport source (output valid, output data_word, input ready);
   modport sink (input valid, input data_word, output ready);
endinterface
`default_nettype wire

### rtl/core/q4kd_rsp_if.sv
// Response channel interface: valid/ready plus eight dequantized values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface q4kd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  first_index;
   logic [31:0] value_0;
   logic [31:0] value_1;
   logic [31:0] value_2;
   logic [31:0] value_3;
   logic [31:0] value_4;
   logic [31:0] value_5;
   logic [31:0] value_6;
   logic [31:0] value_7;
   logic        last_of_block;

   modport source (output valid, output first_index, output value_0, output value_1,
                   output value_2, output value_3, output value_4, output value_5,
                   output value_6, output value_7, output last_of_block, input ready);
   modport sink (input valid, input first_index, input value_0, input value_1,
                 input value_2, input value_3, input value_4, input value_5,
                 input value_6, input value_7, input last_of_block, output ready);
endinterface
`default_nettype wire

### rtl/core/q4kd_scale.sv
// Segment scale unit: unpacks 6-bit scale/min and forms d*sc and dmin*m in fp16.
// Depends on q4kd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module q4kd_scale (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [2:0]       seg,
   input  wire logic [15:0]      d,
   input  wire logic [15:0]      dmin,
   input  wire logic [11:0][7:0] psb,
   output logic      [15:0]      dsc,
   output logic      [15:0]      dmm
);
   import q4kd_pkg::*;

   logic [7:0][5:0] sc_all;
   logic [7:0][5:0] mn_all;
   logic [15:0]     dsc_ff;
   logic [15:0]     dsc_in;
   logic [15:0]     dmm_ff;
   logic [15:0]     dmm_in;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         sc_all[j] = psb[j][5:0];
         mn_all[j] = psb[j + 4][5:0];
         sc_all[j + 4] = {psb[j][7:6], psb[j + 8][3:0]};
         mn_all[j + 4] = {psb[j + 4][7:6], psb[j + 8][7:4]};
      end
   end

   assign dsc_in = en ? mul_h(d, sc_all[seg]) : dsc_ff;
   assign dmm_in = en ? mul_h(dmin, mn_all[seg]) : dmm_ff;

   always_ff @(posedge clock) begin
      dsc_ff <= dsc_in;
      dmm_ff <= dmm_in;
   end

   assign dsc = dsc_ff;
   assign dmm = dmm_ff;
endmodule
`default_nettype wire

### rtl/core/q4kd_lane.sv
// One dequantization lane: q*dsc, minus dmm, then output encoding.
// Depends on q4kd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module q4kd_lane (
   input  wire logic                         clock,
   input  wire q4kd_pkg::q4kd_lane_ctrl_type ctrl,
   input  wire logic [3:0]                   nib,
   input  wire logic [15:0]                  dsc,
   input  wire logic [15:0]                  dmm,
   input  wire logic [1:0]                   fmt,
   output logic      [31:0]                  value
);
   import q4kd_pkg::*;

   logic [15:0] prod_ff;
   logic [15:0] prod_in;
   logic [15:0] diff_ff;
   logic [15:0] diff_in;

   assign prod_in = ctrl.prod_en ? mul_h(dsc, {2'd0, nib}) : prod_ff;
   assign diff_in = ctrl.diff_en ? sub_h(prod_ff, dmm) : diff_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      diff_ff <= diff_in;
   end

   assign value = encode_h(diff_ff, fmt);
endmodule
`default_nettype wire

### rtl/core/q4_k_block_dequantizer_top.sv
// Q4_K block dequantizer top level: sequencer, header store, lanes, output register.
// Depends on q4kd_pkg, q4kd_req_if, q4kd_rsp_if, q4kd_scale, q4kd_lane.
//
// Usage:
//  - req_ch carries one 64-bit little-endian word of a 144-byte Q4_K block per request.
//    Words 0 and 1 of each block are the header (d, dmin, packed scales); no response.
//  - Each data word (2..17) gives two responses on rsp_ch: low nibbles first, then
//    high nibbles, eight values each, element index of value_0 in first_index.
//  - csr_we/csr_wdata set the output encoding (0 fp16, 1 bf16, 2 or 3 fp32); write
//    only while the block is idle.
// Timing:
//  - A header word leaves the sequencer idle. A data word keeps req_ch.ready low until
//    both of its responses are loaded into the output register: per response, scale unit,
//    lane multiply, lane subtract and output load each take a sequencer step, in that order.
//  - req_ch.ready is high only while the sequencer is idle; the last response can
//    still wait in the output register while the next word is taken.
//  - If the receiver stalls, the sequencer holds in its emit step until the output
//    register frees up. Nothing is dropped.
// Reset: synchronous, active high; clears sequencer, word position, output valid and
// format (fp16). Header contents are don't-care until the next header is received.
`timescale 1ns / 1ps
`default_nettype none
`include "q4_k_block_dequantizer_top_assert.svh"
module q4_k_block_dequantizer_top (
   input  wire logic       clock,
   input  wire logic       reset,
   q4kd_req_if.sink        req_ch,
   q4kd_rsp_if.source      rsp_ch,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_wdata
);
   import q4kd_pkg::*;

   q4kd_state_type     state_ff, state_in;
   logic [4:0]         pos_ff, pos_in;
   logic               r_ff, r_in;
   logic [1:0]         fmt_ff, fmt_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // header store
   logic [15:0]        d_ff, d_in;
   logic [15:0]        dmin_ff, dmin_in;
   logic [11:0][7:0]   psb_ff, psb_in;

   // current data word
   logic [63:0]        word_ff, word_in;
   logic [3:0]         dw_ff, dw_in;
   logic               last_ff, last_in;

   // output register
   logic [7:0]         idx_ff, idx_in;
   logic               lob_ff, lob_in;
   logic [LANES-1:0][31:0] val_ff, val_in;

   logic               acc;
   logic               load;
   logic               scale_en;
   q4kd_lane_ctrl_type lane_ctrl;
   logic [15:0]        dsc;
   logic [15:0]        dmm;
   logic [LANES-1:0][31:0] lane_val;

   assign acc = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      r_in      = r_ff;
      load      = 1'b0;
      scale_en  = 1'b0;
      lane_ctrl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc && pos_ff >= FIRST_DATA_WORD) begin
               state_in = ST_SCALE;
               r_in     = 1'b0;
            end
         end
         ST_SCALE: begin
            scale_en = 1'b1;
            state_in = ST_PROD;
         end
         ST_PROD: begin
            lane_ctrl.prod_en = 1'b1;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            lane_ctrl.diff_en = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load = 1'b1;
               if (r_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  r_in     = 1'b1;
                  state_in = ST_SCALE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // word tracking and header capture
   always_comb begin
      pos_in  = pos_ff;
      d_in    = d_ff;
      dmin_in = dmin_ff;
      psb_in  = psb_ff;
      word_in = word_ff;
      dw_in   = dw_ff;
      last_in = last_ff;
      if (acc) begin
         pos_in = (pos_ff == LAST_WORD) ? 5'd0 : pos_ff + 5'd1;
         if (pos_ff == 5'd0) begin
            d_in    = req_ch.data_word[15:0];
            dmin_in = req_ch.data_word[31:16];
            for (int k = 0; k < 4; k++) psb_in[k] = req_ch.data_word[32 + 8*k +: 8];
         end else if (pos_ff == 5'd1) begin
            for (int k = 0; k < 8; k++) psb_in[4 + k] = req_ch.data_word[8*k +: 8];
         end else begin
            word_in = req_ch.data_word;
            dw_in   = 4'(pos_ff - FIRST_DATA_WORD);
            last_in = (pos_ff == LAST_WORD);
         end
      end
   end

   assign fmt_in = csr_we ? csr_wdata : fmt_ff;

   // merge lane results into the output register
   assign idx_in = load ? {dw_ff[3:2], r_ff, dw_ff[1:0], 3'd0} : idx_ff;
   assign lob_in = load ? (r_ff && last_ff) : lob_ff;
   assign val_in = load ? lane_val : val_ff;
   assign rsp_valid_in = load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= 5'd0;
         r_ff         <= 1'b0;
         fmt_ff       <= FMT_FP16;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         r_ff         <= r_in;
         fmt_ff       <= fmt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff    <= d_in;
      dmin_ff <= dmin_in;
      psb_ff  <= psb_in;
      word_ff <= word_in;
      dw_ff   <= dw_in;
      last_ff <= last_in;
      idx_ff  <= idx_in;
      lob_ff  <= lob_in;
      val_ff  <= val_in;
   end

   q4kd_scale u_scale (
      .clock (clock),
      .en    (scale_en),
      .seg   ({dw_ff[3:2], r_ff}),
      .d     (d_ff),
      .dmin  (dmin_ff),
      .psb   (psb_ff),
      .dsc   (dsc),
      .dmm   (dmm)
   );

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      q4kd_lane u_lane (
         .clock (clock),
         .ctrl  (lane_ctrl),
         .nib   (r_ff ? word_ff[8*g+4 +: 4] : word_ff[8*g +: 4]),
         .dsc   (dsc),
         .dmm   (dmm),
         .fmt   (fmt_ff),
         .value (lane_val[g])
      );
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.first_index   = idx_ff;
   assign rsp_ch.last_of_block = lob_ff;
   assign rsp_ch.value_0       = val_ff[0];
   assign rsp_ch.value_1       = val_ff[1];
   assign rsp_ch.value_2       = val_ff[2];
   assign rsp_ch.value_3       = val_ff[3];
   assign rsp_ch.value_4       = val_ff[4];
   assign rsp_ch.value_5       = val_ff[5];
   assign rsp_ch.value_6       = val_ff[6];
   assign rsp_ch.value_7       = val_ff[7];

   `Q4KD_ASSERT_IMP(a_pos_range, clock, reset, 1'b1, pos_ff <= LAST_WORD, "word position out of range")
   `Q4KD_ASSERT_NXT(a_hdr_no_rsp, clock, reset, acc && pos_ff < FIRST_DATA_WORD, state_ff == ST_IDLE, "header word started work")
   `Q4KD_ASSERT_IMP(a_last_idx, clock, reset, rsp_valid_ff && lob_ff, idx_ff == 8'hF8, "last flag on wrong segment")
   `Q4KD_ASSERT_IMP(a_load_free, clock, reset, load, !rsp_valid_ff || rsp_ch.ready, "output overwritten")
endmodule
`default_nettype wire
